// ===== src/coap_message_serializer_assert.svh =====
// Assertion helpers used by the checker file
`ifndef COAP_MESSAGE_SERIALIZER_ASSERT_SVH
`define COAP_MESSAGE_SERIALIZER_ASSERT_SVH

// Clocked assertion, muted while reset is asserted
`define CMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, but also checked during reset
`define CMS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/cms_pkg.sv =====
package cms_pkg;

    typedef enum logic [1:0] {
        CMD_HEADER  = 2'd0,
        CMD_OPTION  = 2'd1,
        CMD_VALUE   = 2'd2,
        CMD_PAYLOAD = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_LEN  = 3'd1,
        ST_ORDER     = 3'd2,
        ST_NO_ROOM   = 3'd3,
        ST_BAD_TOKEN = 3'd4
    } status_t;

    localparam int MAX_BYTES = 12;

    localparam logic [15:0] CAP_RESET      = 16'd1152;
    localparam logic [1:0]  COAP_VERSION   = 2'd1;
    localparam logic [3:0]  HDR_BYTES      = 4'd4;
    localparam logic [3:0]  MAX_TOKEN      = 4'd8;
    localparam logic [8:0]  EXT1_BASE      = 9'd13;
    localparam logic [8:0]  EXT2_BASE      = 9'd269;
    localparam logic [3:0]  NIB_EXT1       = 4'hD;
    localparam logic [3:0]  NIB_EXT2       = 4'hE;
    localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;

endpackage

// ===== src/coap_message_serializer.sv =====
// Channel   Direction  Handshake             Carries
// in        input      in_valid / in_ready   one command and its fields
// out       output     out_valid / out_ready one message byte or one error result
// cfg       input      cfg_wr_en             capacity register write
//
// Each command is encoded in the cycle it is accepted and lands in a 12-entry
// byte register that drains one result per cycle. A command produces from 1 to
// 12 results; the next command is taken in the cycle the last result
// transfers, so value bytes stream at one per cycle.
// Stalls on out_ready hold the byte register and back-pressure in_ready.
// Reset empties the byte register and clears message length and option number.
module coap_message_serializer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [1:0]  msg_type,
    input  logic [7:0]  msg_code,
    input  logic [15:0] message_ident,
    input  logic [63:0] token_bytes,
    input  logic [3:0]  token_count,
    input  logic [15:0] option_number,
    input  logic [16:0] item_length,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        last,
    output logic [2:0]  status
);
    import cms_pkg::*;

    logic [15:0] cap_reg;
    logic [16:0] msg_len_reg, msg_len_next;
    logic [15:0] prev_opt_reg, prev_opt_next;
    logic [7:0]  bytes_reg [MAX_BYTES];
    logic [7:0]  bytes_next [MAX_BYTES];
    logic [3:0]  remain_reg, remain_next;
    logic        bvalid_reg, bvalid_next;
    status_t     status_reg, status_next;

    logic        load;
    logic        out_fire;

    // option encoding
    logic [15:0] delta;
    logic [15:0] delta_x2;
    logic [3:0]  d_nib;
    logic [1:0]  d_cnt;
    logic [7:0]  d_ext0, d_ext1;
    logic [15:0] len_x2;
    logic [3:0]  l_nib;
    logic [1:0]  l_cnt;
    logic [7:0]  l_ext0, l_ext1;
    logic [18:0] opt_total;
    logic [18:0] pay_total;
    logic [4:0]  hdr_total;

    assign load     = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign in_ready = (remain_reg == 4'd0) || (out_ready && remain_reg == 4'd1);

    assign out_valid  = (remain_reg != 4'd0);
    assign out_byte   = bytes_reg[0];
    assign byte_valid = bvalid_reg;
    assign last       = (remain_reg == 4'd1);
    assign status     = status_reg;

    // Nibble and extension bytes for delta and length
    always_comb
    begin
        delta    = option_number - prev_opt_reg;
        delta_x2 = delta - 16'(EXT2_BASE);
        d_ext1   = delta_x2[7:0];
        if (delta < 16'(EXT1_BASE))
        begin
            d_nib  = delta[3:0];
            d_cnt  = 2'd0;
            d_ext0 = 8'd0;
        end
        else if (delta < 16'(EXT2_BASE))
        begin
            d_nib  = NIB_EXT1;
            d_cnt  = 2'd1;
            d_ext0 = 8'(delta - 16'(EXT1_BASE));
        end
        else
        begin
            d_nib  = NIB_EXT2;
            d_cnt  = 2'd2;
            d_ext0 = delta_x2[15:8];
        end

        len_x2 = 16'(item_length - 17'(EXT2_BASE));
        l_ext1 = len_x2[7:0];
        if (item_length < 17'(EXT1_BASE))
        begin
            l_nib  = item_length[3:0];
            l_cnt  = 2'd0;
            l_ext0 = 8'd0;
        end
        else if (item_length < 17'(EXT2_BASE))
        begin
            l_nib  = NIB_EXT1;
            l_cnt  = 2'd1;
            l_ext0 = 8'(item_length - 17'(EXT1_BASE));
        end
        else
        begin
            l_nib  = NIB_EXT2;
            l_cnt  = 2'd2;
            l_ext0 = len_x2[15:8];
        end

        opt_total = {2'b00, msg_len_reg} + 19'd1 + {17'd0, d_cnt} + {17'd0, l_cnt}
                  + {2'b00, item_length};
        pay_total = {2'b00, msg_len_reg} + {2'b00, item_length} + 19'd1;
        hdr_total = {1'b0, HDR_BYTES} + {1'b0, token_count};
    end

    // Encode one command into the byte register image
    always_comb
    begin
        for (int i = 0; i < MAX_BYTES; i++)
            bytes_next[i] = 8'd0;
        remain_next   = 4'd1;
        bvalid_next   = 1'b1;
        status_next   = ST_OK;
        msg_len_next  = msg_len_reg;
        prev_opt_next = prev_opt_reg;

        unique case (cmd_t'(command))
            CMD_HEADER:
            begin
                if (token_count > MAX_TOKEN)
                    status_next = ST_BAD_TOKEN;
                else if ({12'd0, hdr_total} > {1'b0, cap_reg})
                    status_next = ST_NO_ROOM;
                else
                begin
                    bytes_next[0] = {COAP_VERSION, msg_type, token_count};
                    bytes_next[1] = msg_code;
                    bytes_next[2] = message_ident[15:8];
                    bytes_next[3] = message_ident[7:0];
                    for (int i = 0; i < 8; i++)
                        bytes_next[4 + i] = token_bytes[8*i +: 8];
                    remain_next   = hdr_total[3:0];
                    msg_len_next  = {12'd0, hdr_total};
                    prev_opt_next = 16'd0;
                end
            end
            CMD_OPTION:
            begin
                if (item_length == 17'd0)
                    status_next = ST_ZERO_LEN;
                else if (option_number < prev_opt_reg)
                    status_next = ST_ORDER;
                else if (opt_total > {3'b000, cap_reg})
                    status_next = ST_NO_ROOM;
                else
                begin
                    bytes_next[0] = {d_nib, l_nib};
                    unique case (d_cnt)
                        2'd0:
                        begin
                            bytes_next[1] = l_ext0;
                            bytes_next[2] = l_ext1;
                        end
                        2'd1:
                        begin
                            bytes_next[1] = d_ext0;
                            bytes_next[2] = l_ext0;
                            bytes_next[3] = l_ext1;
                        end
                        default:
                        begin
                            bytes_next[1] = d_ext0;
                            bytes_next[2] = d_ext1;
                            bytes_next[3] = l_ext0;
                            bytes_next[4] = l_ext1;
                        end
                    endcase
                    remain_next   = 4'd1 + {2'b00, d_cnt} + {2'b00, l_cnt};
                    msg_len_next  = opt_total[16:0];
                    prev_opt_next = option_number;
                end
            end
            CMD_VALUE:
            begin
                bytes_next[0] = data_byte;
            end
            CMD_PAYLOAD:
            begin
                if (item_length == 17'd0)
                    status_next = ST_ZERO_LEN;
                else if (pay_total > {3'b000, cap_reg})
                    status_next = ST_NO_ROOM;
                else
                begin
                    bytes_next[0] = PAYLOAD_MARKER;
                    msg_len_next  = pay_total[16:0];
                end
            end
            default:
            begin
                bytes_next[0] = data_byte;
            end
        endcase

        // errors give a single flagged result and leave state alone
        if (status_next != ST_OK)
        begin
            for (int i = 0; i < MAX_BYTES; i++)
                bytes_next[i] = 8'd0;
            remain_next   = 4'd1;
            bvalid_next   = 1'b0;
            msg_len_next  = msg_len_reg;
            prev_opt_next = prev_opt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CAP_RESET;
            msg_len_reg  <= 17'd0;
            prev_opt_reg <= 16'd0;
            remain_reg   <= 4'd0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            if (load)
            begin
                msg_len_reg  <= msg_len_next;
                prev_opt_reg <= prev_opt_next;
                remain_reg   <= remain_next;
            end
            else if (out_fire)
                remain_reg <= remain_reg - 4'd1;
        end
    end

    // Load a fresh image, or advance the queue by one byte per transfer
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg  <= bytes_next;
            bvalid_reg <= bvalid_next;
            status_reg <= status_next;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < MAX_BYTES - 1; i++)
                bytes_reg[i] <= bytes_reg[i + 1];
            bytes_reg[MAX_BYTES - 1] <= 8'd0;
        end
    end

endmodule

// ===== src/cms_checker.sv =====
`include "coap_message_serializer_assert.svh"

module cms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  command,
    input logic [7:0]  data_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic        byte_valid,
    input logic        last,
    input logic [2:0]  status
);
    import cms_pkg::*;

    // a stalled result holds its byte
    `CMS_ASSERT(a_out_hold,
        out_valid && !out_ready |=> out_valid && $stable(out_byte),
        "output changed while stalled")

    // an error result is alone, flagged and carries no byte
    `CMS_ASSERT(a_err_single,
        out_valid && status != ST_OK |-> last && !byte_valid && out_byte == 8'd0,
        "malformed error result")

    // an empty output side always takes a command
    `CMS_ASSERT(a_idle_ready, !out_valid |-> in_ready, "input stalled while output empty")

    // a value byte comes out alone in the next cycle
    `CMS_ASSERT(a_value_pass,
        in_valid && in_ready && command == CMD_VALUE
            |=> out_valid && last && byte_valid && out_byte == $past(data_byte),
        "value byte not passed through")

endmodule

bind coap_message_serializer cms_checker u_cms_checker (.*);
